@@ hw/rtl/bdq_pkg.sv @@
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int CAP_W     = 7;
    localparam int VAL_W     = 8;
    localparam int IDX_W     = 6;
    localparam int POS_W     = 6;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Operation codes carried by the kind field
    typedef enum logic [3:0] {
        OP_CLEAR   = 4'd0,
        OP_PUSH    = 4'd1,
        OP_POP     = 4'd2,
        OP_SHIFT   = 4'd3,
        OP_UNSHIFT = 4'd4,
        OP_GET     = 4'd5,
        OP_SET     = 4'd6,
        OP_FINDF   = 4'd7,
        OP_FINDL   = 4'd8,
        OP_REMOVE  = 4'd9
    } op_t;

    // Update broadcast to every cell
    typedef enum logic [2:0] {
        CMD_HOLD  = 3'd0,
        CMD_CLEAR = 3'd1,
        CMD_LOAD  = 3'd2,
        CMD_DOWN  = 3'd3,
        CMD_UP    = 3'd4,
        CMD_TRIM  = 3'd5
    } cell_cmd_t;

    // How a cell raises its hit flag into the select tree
    typedef enum logic [1:0] {
        LEAF_NONE  = 2'd0,
        LEAF_AT    = 2'd1,
        LEAF_MATCH = 2'd2
    } leaf_t;

    typedef struct packed {
        cell_cmd_t          cmd;
        leaf_t              leaf;
        logic [VAL_W-1:0]   value;
        logic [CAP_W-1:0]   target;
        logic [CAP_W-1:0]   cap;
    } cell_ctrl_t;

    // Saturate to the built depth, zero acts as one
    function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] c, input int depth);
        logic [CAP_W-1:0] r;
        r = c;
        if (32'(c) > depth)
        begin
            r = CAP_W'(depth);
        end
        if (r == '0)
        begin
            r = CAP_W'(1);
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/bdq_cell.sv @@
`timescale 1ns / 1ps

module bdq_cell
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int POS   = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [VAL_W-1:0] left_data,
    input  logic [VAL_W-1:0] right_data,
    output logic [VAL_W-1:0] data,
    output logic             hit
);

    localparam int PW = ($clog2(DEPTH) > CAP_W) ? $clog2(DEPTH) : CAP_W;
    localparam logic [PW-1:0] MY_POS = PW'(POS);

    logic [VAL_W-1:0] data_reg;
    logic [VAL_W-1:0] data_next;
    logic [PW-1:0]    target_w;
    logic [PW-1:0]    cap_w;

    assign target_w = PW'(ctrl.target);
    assign cap_w    = PW'(ctrl.cap);

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.cmd)
            CMD_HOLD:  data_next = data_reg;
            CMD_CLEAR: data_next = '0;
            CMD_LOAD:
            begin
                if (MY_POS == target_w)
                begin
                    data_next = ctrl.value;
                end
            end
            CMD_DOWN:
            begin
                // close up toward the front from target onward
                if (MY_POS >= target_w)
                begin
                    data_next = right_data;
                end
            end
            CMD_UP:
            begin
                if (MY_POS == '0)
                begin
                    data_next = ctrl.value;
                end
                else if (MY_POS < cap_w)
                begin
                    data_next = left_data;
                end
            end
            CMD_TRIM:
            begin
                if (MY_POS >= cap_w)
                begin
                    data_next = '0;
                end
            end
            default: data_next = data_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.leaf)
            LEAF_NONE:  hit = 1'b0;
            LEAF_AT:    hit = (MY_POS == target_w);
            LEAF_MATCH: hit = (MY_POS < cap_w) && (data_reg == ctrl.value);
            default:    hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

@@ hw/rtl/bdq_tree.sv @@
`timescale 1ns / 1ps

module bdq_tree
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      last,
    input  logic [DEPTH-1:0]          leaf_hit,
    input  logic [VAL_W-1:0]          leaf_data [DEPTH],
    output logic                      root_hit,
    output logic [$clog2(DEPTH)-1:0]  root_pos,
    output logic [VAL_W-1:0]          root_data
);

    localparam int LW = $clog2(DEPTH);
    localparam int NL = 1 << LW;

    // heap order: node n has children 2n and 2n+1, leaves sit at NL..2NL-1
    logic             hit_reg [1:2*NL-1];
    logic [LW-1:0]    pos_reg [1:2*NL-1];
    logic [VAL_W-1:0] dat_reg [1:2*NL-1];

    genvar g;

    for (g = 0; g < NL; g++)
    begin : g_leaf
        if (g < DEPTH)
        begin : g_real
            always_ff @(posedge clk)
            begin
                hit_reg[NL+g] <= leaf_hit[g];
                pos_reg[NL+g] <= LW'(g);
                dat_reg[NL+g] <= leaf_data[g];
            end
        end
        else
        begin : g_pad
            always_ff @(posedge clk)
            begin
                hit_reg[NL+g] <= 1'b0;
                pos_reg[NL+g] <= LW'(g);
                dat_reg[NL+g] <= '0;
            end
        end
    end

    for (g = 1; g < NL; g++)
    begin : g_node
        logic take_right;

        // first match prefers the lower half, last match the upper half
        assign take_right = last ? hit_reg[2*g+1] : !hit_reg[2*g];

        always_ff @(posedge clk)
        begin
            hit_reg[g] <= hit_reg[2*g] | hit_reg[2*g+1];
            pos_reg[g] <= take_right ? pos_reg[2*g+1] : pos_reg[2*g];
            dat_reg[g] <= take_right ? dat_reg[2*g+1] : dat_reg[2*g];
        end
    end

    assign root_hit  = hit_reg[1];
    assign root_pos  = pos_reg[1];
    assign root_data = dat_reg[1];

endmodule

@@ hw/rtl/byte_deque_array_store_top.sv @@
`timescale 1ns / 1ps

// Byte deque with indexed access and search, kept in a row of byte cells.
// Input channel (in_valid/in_stall) carries one request: kind, value, index,
// end_index. Output channel (out_valid/out_stall) returns one result per
// request: read_value, found, position, fill_count, accepted.
// Configuration channel (cfg_valid/cfg_ready) writes capacity; it is ready
// only while no request is in work.
// Work per request, from acceptance to out_valid:
//   clear, push, shift, unshift, set, unused kinds and refused range
//   removals: result loaded directly, with no wait;
//   pop, get, find-first, find-last: result once the registered select
//   tree over the cells has carried the query to its root;
//   range removal: one cell step per removed entry, then the result.
// One request is in work at a time; the next is taken the cycle after the
// previous result is loaded into the output register.
// A stalled result holds in the output register; a finished request waits
// for that register to empty before it updates the cells.
// Reset clears every cell and the fill count and sets capacity to 64.

module byte_deque_array_store_top
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] capacity,

    input  logic             in_valid,
    output logic             in_stall,
    input  logic [3:0]       kind,
    input  logic [VAL_W-1:0] value,
    input  logic [IDX_W-1:0] index,
    input  logic [CAP_W-1:0] end_index,

    output logic             out_valid,
    input  logic             out_stall,
    output logic [VAL_W-1:0] read_value,
    output logic             found,
    output logic [POS_W-1:0] position,
    output logic [CAP_W-1:0] fill_count,
    output logic             accepted
);

    localparam int LW = $clog2(DEPTH);
    // leaf register plus one register per tree level
    localparam logic [CAP_W-1:0] TREE_LAT = CAP_W'(LW + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t           state_reg, state_next;

    // held request
    logic [3:0]       kind_reg;
    logic [VAL_W-1:0] value_reg;
    logic [IDX_W-1:0] index_reg;
    logic [CAP_W-1:0] end_reg;

    logic [CAP_W-1:0] cnt_reg, cnt_next;
    logic [CAP_W-1:0] count_reg, count_next;
    logic [CAP_W-1:0] capacity_reg;

    logic             out_valid_reg, out_valid_next;
    logic [VAL_W-1:0] read_value_reg;
    logic             found_reg;
    logic [POS_W-1:0] position_reg;
    logic [CAP_W-1:0] fill_count_reg;
    logic             accepted_reg;

    // cell row and select tree
    cell_ctrl_t       ctrl;
    logic [VAL_W-1:0] cell_data  [DEPTH];
    logic [VAL_W-1:0] left_data  [DEPTH];
    logic [VAL_W-1:0] right_data [DEPTH];
    logic [DEPTH-1:0] cell_hit;
    logic             root_hit;
    logic [LW-1:0]    root_pos;
    logic [VAL_W-1:0] root_data;
    logic             find_last;

    // decoded request
    logic [CAP_W-1:0] cap_eff;
    logic [CAP_W-1:0] cfg_cap;
    logic             cfg_fire;
    logic             in_fire;
    logic             out_free;
    logic             op_ok;
    logic             wait_done;
    logic             step;
    logic             finish;
    cell_cmd_t        fin_cmd;
    leaf_t            leaf_sel;
    logic [CAP_W-1:0] target_sel;
    logic [CAP_W-1:0] count_after;
    logic [CAP_W-1:0] dif;
    logic [VAL_W-1:0] rd_sel;
    logic             found_sel;
    logic [POS_W-1:0] pos_sel;

    assign cap_eff  = eff_cap(capacity_reg, DEPTH);
    assign cfg_cap  = eff_cap(capacity, DEPTH);

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign dif       = end_reg - CAP_W'(index_reg);
    assign find_last = (kind_reg == OP_FINDL);

    // Decode the held request into its cell update, tree query and result
    always_comb
    begin
        op_ok       = 1'b0;
        wait_done   = 1'b1;
        step        = 1'b0;
        fin_cmd     = CMD_HOLD;
        leaf_sel    = LEAF_NONE;
        target_sel  = '0;
        count_after = count_reg;
        rd_sel      = '0;
        found_sel   = 1'b0;
        pos_sel     = '0;
        unique case (kind_reg)
            OP_CLEAR:
            begin
                op_ok       = 1'b1;
                fin_cmd     = CMD_CLEAR;
                count_after = '0;
            end
            OP_PUSH:
            begin
                op_ok      = (count_reg < cap_eff);
                target_sel = count_reg;
                if (op_ok)
                begin
                    fin_cmd     = CMD_LOAD;
                    count_after = count_reg + CAP_W'(1);
                end
            end
            OP_POP:
            begin
                op_ok      = (count_reg != '0);
                leaf_sel   = LEAF_AT;
                target_sel = count_reg - CAP_W'(1);
                wait_done  = (cnt_reg == TREE_LAT);
                if (op_ok)
                begin
                    rd_sel      = root_data;
                    count_after = count_reg - CAP_W'(1);
                end
            end
            OP_SHIFT:
            begin
                op_ok = (count_reg != '0);
                if (op_ok)
                begin
                    fin_cmd     = CMD_DOWN;
                    rd_sel      = cell_data[0];
                    count_after = count_reg - CAP_W'(1);
                end
            end
            OP_UNSHIFT:
            begin
                op_ok = (cap_eff > CAP_W'(1));
                if (op_ok)
                begin
                    fin_cmd = CMD_UP;
                    if (count_reg < cap_eff)
                    begin
                        count_after = count_reg + CAP_W'(1);
                    end
                end
            end
            OP_GET:
            begin
                op_ok      = (CAP_W'(index_reg) < count_reg);
                leaf_sel   = LEAF_AT;
                target_sel = CAP_W'(index_reg);
                wait_done  = (cnt_reg == TREE_LAT);
                if (op_ok)
                begin
                    rd_sel = root_data;
                end
            end
            OP_SET:
            begin
                op_ok      = (CAP_W'(index_reg) < cap_eff);
                target_sel = CAP_W'(index_reg);
                if (op_ok)
                begin
                    fin_cmd = CMD_LOAD;
                end
            end
            OP_FINDF, OP_FINDL:
            begin
                op_ok     = 1'b1;
                leaf_sel  = LEAF_MATCH;
                wait_done = (cnt_reg == TREE_LAT);
                found_sel = root_hit;
                if (root_hit)
                begin
                    pos_sel = POS_W'(root_pos);
                end
            end
            OP_REMOVE:
            begin
                op_ok      = (CAP_W'(index_reg) < end_reg) && (end_reg <= count_reg);
                target_sel = CAP_W'(index_reg);
                step       = op_ok && (cnt_reg < dif);
                wait_done  = !step;
                if (op_ok)
                begin
                    count_after = count_reg - dif;
                end
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
    end

    assign finish = (state_reg == ST_EXEC) && wait_done && out_free;

    // Drive the cell row: trim on a capacity write, step during a range
    // removal, apply the final update when the result is loaded for output
    always_comb
    begin
        ctrl.cmd    = CMD_HOLD;
        ctrl.leaf   = LEAF_NONE;
        ctrl.value  = value_reg;
        ctrl.target = target_sel;
        ctrl.cap    = cap_eff;
        if (state_reg == ST_IDLE)
        begin
            if (cfg_fire)
            begin
                ctrl.cmd = CMD_TRIM;
                ctrl.cap = cfg_cap;
            end
        end
        else
        begin
            ctrl.leaf = leaf_sel;
            if (step)
            begin
                ctrl.cmd = CMD_DOWN;
            end
            else if (finish)
            begin
                ctrl.cmd = fin_cmd;
            end
        end
    end

    genvar g;

    for (g = 0; g < DEPTH; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign left_data[g] = '0;
        end
        else
        begin : g_inner_l
            assign left_data[g] = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_data[g] = '0;
        end
        else
        begin : g_inner_r
            assign right_data[g] = cell_data[g+1];
        end

        bdq_cell #(
            .DEPTH (DEPTH),
            .POS   (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .left_data  (left_data[g]),
            .right_data (right_data[g]),
            .data       (cell_data[g]),
            .hit        (cell_hit[g])
        );
    end

    bdq_tree #(
        .DEPTH (DEPTH)
    ) u_tree (
        .clk       (clk),
        .last      (find_last),
        .leaf_hit  (cell_hit),
        .leaf_data (cell_data),
        .root_hit  (root_hit),
        .root_pos  (root_pos),
        .root_data (root_data)
    );

    // Sequencer: take a request, count tree or removal cycles, release
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                    cnt_next   = '0;
                end
            end
            ST_EXEC:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
                else if (!wait_done)
                begin
                    cnt_next = cnt_reg + CAP_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cfg_fire)
        begin
            // drop the fill count to the new capacity
            if (count_reg > cfg_cap)
            begin
                count_next = cfg_cap;
            end
        end
        else if (finish)
        begin
            count_next = count_after;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            count_reg     <= '0;
            capacity_reg  <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_fire)
            begin
                capacity_reg <= capacity;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg  <= kind;
            value_reg <= value;
            index_reg <= index;
            end_reg   <= end_index;
        end
        if (finish)
        begin
            read_value_reg <= rd_sel;
            found_reg      <= found_sel;
            position_reg   <= pos_sel;
            fill_count_reg <= count_after;
            accepted_reg   <= op_ok;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign found      = found_reg;
    assign position   = position_reg;
    assign fill_count = fill_count_reg;
    assign accepted   = accepted_reg;

endmodule

@@ tb/bdq_checker.sv @@
`timescale 1ns / 1ps

// Watches the three channels of the byte deque, keeps its own copy of the
// cell row and fill count, and compares every returned result in order.
module bdq_checker
    import bdq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CAP_W-1:0] capacity,

    input  logic             in_valid,
    input  logic             in_stall,
    input  logic [3:0]       kind,
    input  logic [VAL_W-1:0] value,
    input  logic [IDX_W-1:0] index,
    input  logic [CAP_W-1:0] end_index,

    input  logic             out_valid,
    input  logic             out_stall,
    input  logic [VAL_W-1:0] read_value,
    input  logic             found,
    input  logic [POS_W-1:0] position,
    input  logic [CAP_W-1:0] fill_count,
    input  logic             accepted,

    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic             found;
        logic [POS_W-1:0] position;
        logic [CAP_W-1:0] fill_count;
        logic             accepted;
    } outcome_t;

    logic [VAL_W-1:0] cells [DEPTH_DEF];
    logic [CAP_W-1:0] fill;
    logic [CAP_W-1:0] cap_reg;
    outcome_t         pending_results[$];
    outcome_t         want;
    int               errs;

    // Cells in use: saturate at the built depth, zero counts as one
    function automatic int live_cap();
        int c;
        c = int'(cap_reg);
        if (c > DEPTH_DEF)
            c = DEPTH_DEF;
        if (c < 1)
            c = 1;
        return c;
    endfunction

    function automatic void write_capacity(logic [CAP_W-1:0] wd);
        int lim;
        cap_reg = wd;
        lim = live_cap();
        if (fill > lim)
            fill = CAP_W'(lim);
        for (int i = lim; i < DEPTH_DEF; i++)
            cells[i] = '0;
    endfunction

    function automatic outcome_t apply_request(logic [3:0] k, logic [VAL_W-1:0] v,
                                               logic [IDX_W-1:0] ix, logic [CAP_W-1:0] ex);
        outcome_t r;
        int       lim;
        int       span;
        r = '0;
        lim = live_cap();
        case (op_t'(k))
            OP_CLEAR:
            begin
                for (int i = 0; i < DEPTH_DEF; i++)
                    cells[i] = '0;
                fill = '0;
                r.accepted = 1'b1;
            end
            OP_PUSH:
            begin
                if (fill < lim)
                begin
                    cells[IDX_W'(fill)] = v;
                    fill = fill + 1'b1;
                    r.accepted = 1'b1;
                end
            end
            OP_POP:
            begin
                if (fill > 0)
                begin
                    fill = fill - 1'b1;
                    r.read_value = cells[IDX_W'(fill)];
                    r.accepted = 1'b1;
                end
            end
            OP_SHIFT:
            begin
                if (fill > 0)
                begin
                    r.read_value = cells[0];
                    for (int i = 0; i + 1 < lim; i++)
                        cells[i] = cells[i + 1];
                    cells[lim - 1] = '0;
                    fill = fill - 1'b1;
                    r.accepted = 1'b1;
                end
            end
            OP_UNSHIFT:
            begin
                if (lim > 1)
                begin
                    for (int i = lim - 1; i > 0; i--)
                        cells[i] = cells[i - 1];
                    cells[0] = v;
                    if (fill < lim)
                        fill = fill + 1'b1;
                    r.accepted = 1'b1;
                end
            end
            OP_GET:
            begin
                if (ix < fill)
                begin
                    r.read_value = cells[ix];
                    r.accepted = 1'b1;
                end
            end
            OP_SET:
            begin
                if (ix < lim)
                begin
                    cells[ix] = v;
                    r.accepted = 1'b1;
                end
            end
            OP_FINDF:
            begin
                r.accepted = 1'b1;
                for (int i = 0; i < lim; i++)
                begin
                    if (!r.found && cells[i] == v)
                    begin
                        r.found = 1'b1;
                        r.position = POS_W'(i);
                    end
                end
            end
            OP_FINDL:
            begin
                r.accepted = 1'b1;
                for (int i = lim - 1; i >= 0; i--)
                begin
                    if (!r.found && cells[i] == v)
                    begin
                        r.found = 1'b1;
                        r.position = POS_W'(i);
                    end
                end
            end
            OP_REMOVE:
            begin
                if (ix < ex && ex <= fill)
                begin
                    span = int'(ex) - int'(ix);
                    for (int i = int'(ix); i + span < lim; i++)
                        cells[i] = cells[i + span];
                    for (int i = lim - span; i < lim; i++)
                        cells[i] = '0;
                    fill = fill - CAP_W'(span);
                    r.accepted = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.fill_count = fill;
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH_DEF; i++)
                cells[i] = '0;
            fill = '0;
            cap_reg = CAP_RESET;
            pending_results.delete();
            errs = 0;
            pending <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                write_capacity(capacity);
            // Retire before predicting: a result can never belong to a request
            // taken at the same edge
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result returned with no request outstanding");
                    errs++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("read_value", want.read_value, read_value);
                    check_field("found", 8'(want.found), 8'(found));
                    check_field("position", 8'(want.position), 8'(position));
                    check_field("fill_count", 8'(want.fill_count), 8'(fill_count));
                    check_field("accepted", 8'(want.accepted), 8'(accepted));
                end
            end
            if (in_valid && !in_stall)
                pending_results.push_back(apply_request(kind, value, index, end_index));
            pending <= pending_results.size();
            fail_count <= errs;
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import bdq_pkg::*;

    // Kinds past the last operation code; the block must ignore them
    localparam logic [3:0] KIND_SPARE_LO = 4'd10;
    localparam logic [3:0] KIND_SPARE_HI = 4'd15;
    // Longest request (a full 64-entry range removal) plus margin
    localparam int DRAIN_CYCLES = 80;
    // Receiver hold-off long enough to back the block up into its input
    localparam int HOLD_CYCLES = 300;

    logic             clk = 1'b0;
    logic             rst_n;

    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] capacity;

    logic             in_valid;
    logic             in_stall;
    logic [3:0]       kind;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic [CAP_W-1:0] end_index;

    logic             out_valid;
    logic             out_stall;
    logic [VAL_W-1:0] read_value;
    logic             found;
    logic [POS_W-1:0] position;
    logic [CAP_W-1:0] fill_count;
    logic             accepted;

    int               fail_count;
    int               pending;

    // Idle rates, in percent, for the sender and the receiver
    int               idle_pct  = 15;
    int               stall_pct = 15;
    // Effective capacity last written, used to aim indexes at live cells
    int               cap_now   = 64;
    // Raised by the stimulus to ask the receiver for one long hold-off
    bit               hold_go   = 1'b0;

    always #10 clk = ~clk;

    byte_deque_array_store_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .capacity   (capacity),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .value      (value),
        .index      (index),
        .end_index  (end_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .found      (found),
        .position   (position),
        .fill_count (fill_count),
        .accepted   (accepted)
    );

    bdq_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .capacity   (capacity),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .value      (value),
        .index      (index),
        .end_index  (end_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .found      (found),
        .position   (position),
        .fill_count (fill_count),
        .accepted   (accepted),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one request, idling at random first; hold the payload until taken.
    // Reading in_stall right after the edge sees the value that edge sampled.
    task automatic send(logic [3:0] k, logic [VAL_W-1:0] v, logic [IDX_W-1:0] ix,
                        logic [CAP_W-1:0] ex);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        value     <= v;
        index     <= ix;
        end_index <= ex;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every request has returned its result, then
    // let the block finish any cell update still in flight. The first edge
    // lets the checker count the request taken at the last edge.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Write capacity while the block is idle
    task automatic set_capacity(logic [CAP_W-1:0] c);
        settle();
        cfg_valid <= 1'b1;
        capacity  <= c;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cap_now = (c > DEPTH_DEF) ? DEPTH_DEF : ((c == 0) ? 1 : int'(c));
    endtask

    // One random request. Pushes outweigh removals so the store fills up;
    // values mostly come from a small set so that searches hit.
    task automatic random_request();
        int               pick;
        logic [3:0]       k;
        logic [VAL_W-1:0] v;
        logic [IDX_W-1:0] ix;
        logic [CAP_W-1:0] ex;
        pick = $urandom_range(99);
        if (pick < 28)
            k = OP_PUSH;
        else if (pick < 36)
            k = OP_UNSHIFT;
        else if (pick < 46)
            k = OP_POP;
        else if (pick < 54)
            k = OP_SHIFT;
        else if (pick < 63)
            k = OP_GET;
        else if (pick < 71)
            k = OP_SET;
        else if (pick < 79)
            k = OP_FINDF;
        else if (pick < 87)
            k = OP_FINDL;
        else if (pick < 96)
            k = OP_REMOVE;
        else if (pick < 98)
            k = OP_CLEAR;
        else
            k = 4'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        v  = ($urandom_range(99) < 65) ? VAL_W'($urandom_range(7)) : VAL_W'($urandom);
        ix = ($urandom_range(99) < 75) ? IDX_W'($urandom_range(cap_now - 1))
                                       : IDX_W'($urandom);
        // Keep most removals short; a few span far or are malformed
        pick = $urandom_range(99);
        if (pick < 80)
            ex = CAP_W'(ix) + CAP_W'($urandom_range(1, 4));
        else if (pick < 90)
            ex = CAP_W'($urandom_range(int'(ix) + 1, DEPTH_DEF));
        else
            ex = CAP_W'($urandom);
        send(k, v, ix, ex);
    endtask

    task automatic random_burst(int n);
        repeat (n)
            random_request();
    endtask

    // Receiver: stall at random, or hold off for a long stretch on request
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                hold_go = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Hard stop in case a handshake never completes
    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        capacity  <= CAP_RESET;
        in_valid  <= 1'b0;
        kind      <= OP_CLEAR;
        value     <= '0;
        index     <= '0;
        end_index <= '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass at reset capacity: empty-store refusals, both ends,
        // indexed access past the fill count, searches into the zero tail,
        // malformed and valid range removals, spare kinds
        send(OP_CLEAR,   8'h00, 6'd0,  7'd0);
        send(OP_POP,     8'h00, 6'd0,  7'd0);
        send(OP_SHIFT,   8'h00, 6'd0,  7'd0);
        send(OP_GET,     8'h00, 6'd0,  7'd0);
        send(OP_PUSH,    8'hFF, 6'd0,  7'd0);
        send(OP_PUSH,    8'h00, 6'd0,  7'd0);
        send(OP_UNSHIFT, 8'hA5, 6'd0,  7'd0);
        send(OP_GET,     8'h00, 6'd0,  7'd0);
        send(OP_GET,     8'h00, 6'd2,  7'd0);
        send(OP_GET,     8'h00, 6'd63, 7'd0);
        send(OP_SET,     8'h5A, 6'd63, 7'd0);
        send(OP_SET,     8'h81, 6'd1,  7'd0);
        send(OP_FINDF,   8'h5A, 6'd0,  7'd0);
        send(OP_FINDL,   8'h00, 6'd0,  7'd0);
        send(OP_FINDF,   8'h00, 6'd0,  7'd0);
        send(OP_FINDL,   8'h77, 6'd0,  7'd0);
        send(OP_REMOVE,  8'h00, 6'd2,  7'd2);
        send(OP_REMOVE,  8'h00, 6'd0,  7'd4);
        send(OP_REMOVE,  8'h00, 6'd63, 7'd127);
        send(OP_REMOVE,  8'h00, 6'd0,  7'd1);
        send(KIND_SPARE_LO, 8'h3C, 6'd1, 7'd2);
        send(KIND_SPARE_HI, 8'hC3, 6'd0, 7'd0);
        send(OP_POP,     8'h00, 6'd0,  7'd0);
        send(OP_SHIFT,   8'h00, 6'd0,  7'd0);
        send(OP_FINDF,   8'h5A, 6'd0,  7'd0);
        random_burst(300);

        // Single-cell store: unshift refused, push fills it at once
        set_capacity(7'd1);
        send(OP_UNSHIFT, 8'h11, 6'd0, 7'd0);
        send(OP_PUSH,    8'h3C, 6'd0, 7'd0);
        send(OP_PUSH,    8'h3D, 6'd0, 7'd0);
        send(OP_SET,     8'h22, 6'd1, 7'd0);
        send(OP_SHIFT,   8'h00, 6'd0, 7'd0);
        random_burst(80);

        // Zero behaves as one
        set_capacity(7'd0);
        random_burst(60);

        // Unshift on a full store drops the last entry
        set_capacity(7'd2);
        send(OP_PUSH,    8'h01, 6'd0, 7'd0);
        send(OP_PUSH,    8'h02, 6'd0, 7'd0);
        send(OP_UNSHIFT, 8'h03, 6'd0, 7'd0);
        random_burst(80);

        // Oversized write saturates; run one long stretch with no idling
        set_capacity(7'd127);
        idle_pct  = 0;
        stall_pct = 0;
        random_burst(150);
        idle_pct  = 15;
        stall_pct = 15;

        // Shrink a filled store, then back the block up behind a long hold-off
        set_capacity(7'($urandom_range(3, 63)));
        hold_go = 1'b1;
        random_burst(150);

        set_capacity(7'd64);
        random_burst(330);

        settle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_cell.sv
hw/rtl/bdq_tree.sv
hw/rtl/byte_deque_array_store_top.sv
tb/bdq_checker.sv
tb/tb_top.sv
